// ===== design/kmer_bitmap_membership_defines.svh =====
// ----------------------------------------------------------------------------
// kmer_bitmap_membership_defines.svh
// Assertion macros for the k-mer presence bitmap block.
// ----------------------------------------------------------------------------
`ifndef KMER_BITMAP_MEMBERSHIP_DEFINES_SVH
`define KMER_BITMAP_MEMBERSHIP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during rst
`define KBM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, sampled on clk, off during rst
`define KBM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KBM_ASSERT_IMP(label, ante, cons, msg)
`define KBM_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ===== design/kbm_pkg.sv =====
// ----------------------------------------------------------------------------
// kbm_pkg
// Shared types and field widths of the k-mer presence bitmap block.
// ----------------------------------------------------------------------------
package kbm_pkg;

  localparam int KMER_W     = 20;
  localparam int CODES_W    = 30;
  localparam int BASE_W     = 3;
  localparam int CMD_W      = 2;
  localparam int ROLL_W     = 20;
  localparam int COUNT_W    = 21;
  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD        = 2'd0,
    CMD_ADD_RC     = 2'd1,
    CMD_FULL_CHECK = 2'd2,
    CMD_ROLL_CHECK = 2'd3
  } cmd_t;

  typedef struct packed {
    logic full_invalid;
    logic roll_invalid;
  } flags_t;

endpackage

// ===== design/kbm_bitmap_ram.sv =====
// ----------------------------------------------------------------------------
// kbm_bitmap_ram
// One-bit-wide bitmap memory, one write port, one registered read port.
// ----------------------------------------------------------------------------
module kbm_bitmap_ram #(
  parameter int ADDR_W = 20
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic              wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic              rdata
);

  logic mem [0:(1 << ADDR_W)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read returns the old bit on a same-cycle write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/kbm_index.sv =====
// ----------------------------------------------------------------------------
// kbm_index
// Builds the bitmap indexes: forward, reverse complement, full and rolling.
// ----------------------------------------------------------------------------
module kbm_index #(
  parameter int KMER_LEN = 10
) (
  input  logic [kbm_pkg::KMER_W-1:0]  packed_kmer,
  input  logic [kbm_pkg::CODES_W-1:0] base_codes,
  input  logic [kbm_pkg::BASE_W-1:0]  next_base,
  input  logic [2*KMER_LEN-1:0]       window_index,
  output logic [2*KMER_LEN-1:0]       fwd_idx,
  output logic [2*KMER_LEN-1:0]       rc_idx,
  output logic [2*KMER_LEN-1:0]       full_idx,
  output logic [2*KMER_LEN-1:0]       roll_idx,
  output kbm_pkg::flags_t             flags
);

  localparam int IDX_W   = 2 * KMER_LEN;
  localparam int CODE_BW = 3 * KMER_LEN;

  logic [kbm_pkg::KMER_W+IDX_W-1:0]    kmer_ext;
  logic [kbm_pkg::CODES_W+CODE_BW-1:0] codes_ext;
  logic [CODE_BW-1:0]                  codes;
  logic [KMER_LEN-1:0]                 bad_code;

  // fields wider than the index are cut, narrower ones zero-filled
  assign kmer_ext  = {{IDX_W{1'b0}}, packed_kmer};
  assign codes_ext = {{CODE_BW{1'b0}}, base_codes};
  assign fwd_idx   = kmer_ext[IDX_W-1:0];
  assign codes     = codes_ext[CODE_BW-1:0];

  for (genvar i = 0; i < KMER_LEN; i++) begin : g_base
    // complement of a 2-bit base is 3 - b, i.e. bitwise not
    assign rc_idx[2*i +: 2]   = ~fwd_idx[2*(KMER_LEN-1-i) +: 2];
    assign full_idx[2*i +: 2] = codes[3*i +: 2];
    assign bad_code[i]        = codes[3*i+2];
  end

  assign roll_idx           = (window_index << 2) | IDX_W'(next_base[1:0]);
  assign flags.full_invalid = |bad_code;
  assign flags.roll_invalid = next_base[2];

endmodule

// ===== design/kmer_bitmap_membership.sv =====
// ----------------------------------------------------------------------------
// kmer_bitmap_membership
// Presence bitmap over all DNA k-mers with add, full and rolling checks.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one command transaction: s_tuser is the command, s_tdata the
//   k-mer, base codes and next base. m_* returns exactly one result per
//   command: m_tuser flags an invalid base, m_tdata the present bit, the
//   kept rolling index and the running count of set bits.
// Sequencing: the result is loaded from ST_LOOK, or from ST_RC after
//   ST_LOOK for add with reverse complement.
// Commands: a new command is taken only once the last one is through. The
//   bitmap memory has one registered read and one write port, so each bit
//   is a read in one cycle and a conditional write-back in the next; the
//   reverse-complement add does this twice.
// Reset: rst clears the window index, count and result slot, then the
//   block sweeps the bitmap writing zeros, one bit per cycle, over all
//   4^KMER_LEN bits (1,048,576 at KMER_LEN = 10); s_tready stays low
//   until the sweep ends.
// Stall: the result sits in the output register until m_tready; no new
//   command is taken while that register is occupied and not draining.
// ----------------------------------------------------------------------------
`include "kmer_bitmap_membership_defines.svh"

module kmer_bitmap_membership #(
  parameter int KMER_LEN = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [19:0] packed_kmer, [49:20] base_codes, [52:50] next_base, [55:53] zero
  input  logic [kbm_pkg::IN_DATA_W-1:0]    s_tdata,
  // [1:0] cmd
  input  logic [kbm_pkg::IN_USER_W-1:0]    s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [0] present, [20:1] rolling_index, [41:21] kmer_total, [47:42] zero
  output logic [kbm_pkg::OUT_DATA_W-1:0]   m_tdata,
  // [0] base_invalid
  output logic [kbm_pkg::OUT_USER_W-1:0]   m_tuser
);

  localparam int IDX_W   = 2 * KMER_LEN;
  localparam int ROLL_W  = kbm_pkg::ROLL_W;
  localparam int COUNT_W = kbm_pkg::COUNT_W;
  localparam int KMER_LO = 0;
  localparam int CODE_LO = KMER_LO + kbm_pkg::KMER_W;
  localparam int BASE_LO = CODE_LO + kbm_pkg::CODES_W;
  localparam int PAD_W   = kbm_pkg::OUT_DATA_W - 1 - ROLL_W - COUNT_W;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,   // zero sweep after reset
    ST_IDLE  = 4'b0010,   // waiting for a command
    ST_LOOK  = 4'b0100,   // first bit read back, write-back for add
    ST_RC    = 4'b1000    // reverse-complement bit read back, write-back
  } state_t;

  // input field split
  kbm_pkg::cmd_t                cmd;
  logic [kbm_pkg::KMER_W-1:0]   packed_kmer;
  logic [kbm_pkg::CODES_W-1:0]  base_codes;
  logic [kbm_pkg::BASE_W-1:0]   next_base;

  assign cmd         = kbm_pkg::cmd_t'(s_tuser[kbm_pkg::CMD_W-1:0]);
  assign packed_kmer = s_tdata[KMER_LO +: kbm_pkg::KMER_W];
  assign base_codes  = s_tdata[CODE_LO +: kbm_pkg::CODES_W];
  assign next_base   = s_tdata[BASE_LO +: kbm_pkg::BASE_W];

  // registers
  state_t               state, state_next;
  logic [IDX_W-1:0]     clear_addr;
  kbm_pkg::cmd_t        cmd_q;
  logic                 inval_q;
  logic [IDX_W-1:0]     addr_q;       // forward k-mer or checked index
  logic [IDX_W-1:0]     rc_q;
  logic [IDX_W-1:0]     window_index;
  logic [COUNT_W-1:0]   set_count;
  logic                 out_valid;
  logic                 out_present;
  logic                 out_invalid;
  logic [ROLL_W-1:0]    out_roll;
  logic [COUNT_W-1:0]   out_count;

  // index unit
  logic [IDX_W-1:0]     fwd_idx, rc_idx, full_idx, roll_idx;
  kbm_pkg::flags_t      flags;

  kbm_index #(
    .KMER_LEN     (KMER_LEN)
  ) u_index (
    .packed_kmer  (packed_kmer),
    .base_codes   (base_codes),
    .next_base    (next_base),
    .window_index (window_index),
    .fwd_idx      (fwd_idx),
    .rc_idx       (rc_idx),
    .full_idx     (full_idx),
    .roll_idx     (roll_idx),
    .flags        (flags)
  );

  // bitmap memory
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic                 ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic                 ram_rdata;

  kbm_bitmap_ram #(
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr  (ram_raddr),
    .rdata  (ram_rdata)
  );

  // handshake: the result slot is free at accept, so the result always fits
  logic accept;
  assign s_tready = (state == ST_IDLE) && (!out_valid || m_tready);
  assign accept   = s_tvalid && s_tready;

  // command decode at accept
  logic [IDX_W-1:0] sel_idx;
  logic             sel_inval;

  always_comb begin
    case (cmd)
      kbm_pkg::CMD_FULL_CHECK: begin
        sel_idx   = full_idx;
        sel_inval = flags.full_invalid;
      end
      kbm_pkg::CMD_ROLL_CHECK: begin
        sel_idx   = roll_idx;
        sel_inval = flags.roll_invalid;
      end
      default: begin
        sel_idx   = fwd_idx;
        sel_inval = 1'b0;
      end
    endcase
  end

  // sequencer: read, then for an add write back a set bit if it was clear
  logic count_inc;
  logic load_out;
  logic present_val;

  always_comb begin
    state_next  = state;
    ram_we      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata   = 1'b1;
    ram_raddr   = sel_idx;
    count_inc   = 1'b0;
    load_out    = 1'b0;
    present_val = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clear_addr;
        ram_wdata = 1'b0;
        if (&clear_addr) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        ram_raddr = rc_q;
        case (cmd_q) inside
          kbm_pkg::CMD_ADD, kbm_pkg::CMD_ADD_RC: begin
            present_val = ram_rdata;
            if (!ram_rdata) begin
              ram_we    = 1'b1;
              count_inc = 1'b1;
            end
            if (cmd_q == kbm_pkg::CMD_ADD_RC) begin
              state_next = ST_RC;
            end else begin
              load_out   = 1'b1;
              state_next = ST_IDLE;
            end
          end
          default: begin
            present_val = ram_rdata && !inval_q;
            load_out    = 1'b1;
            state_next  = ST_IDLE;
          end
        endcase
      end
      ST_RC: begin
        // rc read raced the forward write; a palindrome counts as already set
        if (!(ram_rdata || (rc_q == addr_q))) begin
          ram_we    = 1'b1;
          ram_waddr = rc_q;
          count_inc = 1'b1;
        end
        load_out   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  logic [COUNT_W-1:0]      count_next;
  logic [ROLL_W+IDX_W-1:0] window_ext;

  assign count_next = count_inc ? set_count + COUNT_W'(1) : set_count;
  assign window_ext = {{ROLL_W{1'b0}}, window_index};

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clear_addr   <= '0;
      window_index <= '0;
      set_count    <= '0;
      out_valid    <= 1'b0;
    end else begin
      state     <= state_next;
      set_count <= count_next;
      if (state == ST_CLEAR) begin
        clear_addr <= clear_addr + IDX_W'(1);
      end
      // a valid check moves the kept window
      if (accept && !sel_inval &&
          (cmd == kbm_pkg::CMD_FULL_CHECK || cmd == kbm_pkg::CMD_ROLL_CHECK)) begin
        window_index <= sel_idx;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // command context and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= cmd;
      addr_q  <= sel_idx;
      rc_q    <= rc_idx;
      inval_q <= sel_inval;
    end
    if (state == ST_LOOK) begin
      out_present <= present_val;
    end
    if (load_out) begin
      out_invalid <= inval_q;
      out_roll    <= window_ext[ROLL_W-1:0];
      out_count   <= count_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{PAD_W{1'b0}}, out_count, out_roll, out_present};
  assign m_tuser  = out_invalid;

  // checks
  `KBM_ASSERT_IMP(a_no_write_idle, state == ST_IDLE, !ram_we, "bitmap written while idle")
  `KBM_ASSERT_IMP(a_clear_blocks, state == ST_CLEAR, !s_tready, "command taken during clear")
  `KBM_ASSERT_NXT(a_count_step, 1'b1, set_count == $past(set_count) || set_count == $past(set_count) + COUNT_W'(1), "set count moved by more than one")
  `KBM_ASSERT_IMP(a_load_free, load_out, !out_valid || $past(m_tready), "result slot overwritten")
  `KBM_ASSERT_NXT(a_accept_look, accept, state == ST_LOOK, "accept did not start a lookup")

endmodule
